/* design/cfa_tm_pkg.sv */
// Shared constants, types and coefficient tables of the tone mapping core.
`default_nettype none

package cfa_tm_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int KERNEL_SIZE    = 5;
  localparam int NUM_TAPS       = KERNEL_SIZE * KERNEL_SIZE;
  localparam int CENTER_TAP     = NUM_TAPS / 2;
  localparam int RING_BITS      = 3;
  localparam int MAX_HEIGHT     = 2048;
  localparam int MIN_SIZE       = 5;
  localparam int HEIGHT_BITS    = 12;
  localparam int COL_BITS       = 13;
  localparam int WIDTH_BITS     = 14;
  localparam int SAMPLE_BITS    = 16;
  localparam int WEIGHT_BITS    = 29;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int TONE_BITS      = 8;

  localparam logic [31:0] NORM_SCALE_RESET = 32'd65537;
  localparam logic [11:0] FRAME_SIZE_RESET = 12'd2048;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NORM_SCALE   = 3'd0,
    CFG_K1_OFFSET    = 3'd1,
    CFG_K2_OFFSET    = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_STEP,
    S_BLUR,
    S_BLUR_WAIT,
    S_SUM,
    S_MUL,
    S_DIV,
    S_DIV_WAIT,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic                   capture_pixel;
    logic                   write_f;
    logic [HEIGHT_BITS-1:0] write_row;
    logic [COL_BITS-1:0]    write_col;
    logic                   blur_start;
    logic                   stage_two;
    logic [HEIGHT_BITS-1:0] center_row;
    logic [COL_BITS-1:0]    center_col;
    logic [WIDTH_BITS-1:0]  frame_w;
    logic [HEIGHT_BITS-1:0] frame_h;
    logic                   prep_sum;
    logic                   prep_mul;
    logic                   div_start;
    logic                   write_b;
    logic                   load_out;
    logic                   eof;
  } dp_cmd_t;

  typedef struct packed {
    logic blur_busy;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  typedef logic [WEIGHT_BITS-1:0] weight_tab_t [NUM_TAPS];

  localparam int WIDE_TAPS [KERNEL_SIZE]   = '{11679, 13797, 14584, 13797, 11679};
  localparam int NARROW_TAPS [KERNEL_SIZE] = '{7869, 15328, 19142, 15328, 7869};

  // Two-dimensional weights are the outer product of the one-dimensional taps.
  function automatic weight_tab_t build_weights(input logic narrow);
    weight_tab_t w;
    int t [KERNEL_SIZE];
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      t[i] = narrow ? NARROW_TAPS[i] : WIDE_TAPS[i];
    end
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        w[r * KERNEL_SIZE + c] = WEIGHT_BITS'(t[r] * t[c]);
      end
    end
    return w;
  endfunction

  localparam weight_tab_t WIDE_WEIGHTS   = build_weights(1'b0);
  localparam weight_tab_t NARROW_WEIGHTS = build_weights(1'b1);

endpackage

`default_nettype wire

/* design/cfa_tm_ifs.sv */
// Handshake channel interfaces for pixels, tone values and configuration.
`default_nettype none

interface cfa_tm_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_pixel;
  logic        drain;
  modport source (output valid, output raw_pixel, output drain, input ready);
  modport sink (input valid, input raw_pixel, input drain, output ready);
endinterface

interface cfa_tm_tone_if;
  logic       valid;
  logic       ready;
  logic [7:0] tone_value;
  logic       end_of_frame;
  modport source (output valid, output tone_value, output end_of_frame, input ready);
  modport sink (input valid, input tone_value, input end_of_frame, output ready);
endinterface

interface cfa_tm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/cfa_tone_map_gaussian_core.sv */
// Top level of the two-stage Gaussian tone mapping core with its register bank.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------
//  pixels   | in  | raw_pixel, drain
//  tones    | out | tone_value, end_of_frame
//  cfg      | in  | index, data (register write)
//
// A beat is handled alone: an ignored drain, a step with no stage work and a step
// that runs both stages all finish before the next beat is taken. Each stage issues
// and collects the 25 window reads through the single read port of its line store,
// sets up the offset, product and denominator, runs the bit-serial divider and then
// finishes. Reset is synchronous; the line stores are not cleared.
// A result waits in the output register while the next pixel beat is taken in;
// the core stalls only when a second result is ready.
`default_nettype none

module cfa_tone_map_gaussian_core #(
  parameter int MAX_WIDTH  = cfa_tm_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = cfa_tm_pkg::DEF_PIXEL_BITS
) (
  input  logic          clk,
  input  logic          rst,
  cfa_tm_pix_if.sink    pixels,
  cfa_tm_tone_if.source tones,
  cfa_tm_cfg_if.sink    cfg
);
  import cfa_tm_pkg::*;

  logic [31:0] norm_scale;
  logic [15:0] k1_offset;
  logic [15:0] k2_offset;
  logic [11:0] frame_width;
  logic [11:0] frame_height;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_scale   <= NORM_SCALE_RESET;
      k1_offset    <= '0;
      k2_offset    <= '0;
      frame_width  <= FRAME_SIZE_RESET;
      frame_height <= FRAME_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        CFG_NORM_SCALE:   norm_scale   <= cfg.data;
        CFG_K1_OFFSET:    k1_offset    <= cfg.data[15:0];
        CFG_K2_OFFSET:    k2_offset    <= cfg.data[15:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data[11:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg.data[11:0];
        default: begin
        end
      endcase
    end
  end

  cfa_tm_ctrl #(
    .MaxWidth (MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pixels.valid),
    .in_drain     (pixels.drain),
    .in_ready     (pixels.ready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .status       (status),
    .cmd          (cmd)
  );

  cfa_tm_dp #(
    .MaxWidth  (MAX_WIDTH),
    .PixelBits (PIXEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .raw_pixel    (pixels.raw_pixel),
    .norm_scale   (norm_scale),
    .k1_offset    (k1_offset),
    .k2_offset    (k2_offset),
    .out_valid    (tones.valid),
    .out_ready    (tones.ready),
    .tone_value   (tones.tone_value),
    .end_of_frame (tones.end_of_frame)
  );

endmodule

`default_nettype wire

/* design/cfa_tm_ctrl.sv */
// Sequencing state machine: frame position, step count and stage scheduling.
`default_nettype none

module cfa_tm_ctrl #(
  parameter int MaxWidth = cfa_tm_pkg::DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_drain,
  output logic                   in_ready,
  input  logic [11:0]            frame_width,
  input  logic [11:0]            frame_height,
  input  cfa_tm_pkg::dp_status_t status,
  output cfa_tm_pkg::dp_cmd_t    cmd
);
  import cfa_tm_pkg::*;

  localparam int CW = $clog2(MaxWidth);
  localparam int WW = $clog2(MaxWidth + 1);
  localparam int SW = WW + 13;
  localparam int HB = HEIGHT_BITS;

  ctrl_state_t     state, state_next;
  logic            stage_two, stage_two_next;
  logic            do2, do2_next;
  logic            frame_active, frame_active_next;
  logic [WW-1:0]   cur_w, cur_w_next;
  logic [HB-1:0]   cur_h, cur_h_next;
  logic [CW-1:0]   col_count, col_count_next;
  logic [HB-1:0]   row_count, row_count_next;
  logic [SW-1:0]   step, step_next;
  logic [CW-1:0]   c1, c1_next, c2, c2_next;
  logic [HB-1:0]   r1, r1_next, r2, r2_next;

  logic [WW-1:0]   w_clamp;
  logic [HB-1:0]   h_clamp;
  logic [SW-1:0]   lag;
  logic            frame_done;

  always_comb begin
    if (WIDTH_BITS'(frame_width) < WIDTH_BITS'(MIN_SIZE)) begin
      w_clamp = WW'(MIN_SIZE);
    end else if (WIDTH_BITS'(frame_width) > WIDTH_BITS'(MaxWidth)) begin
      w_clamp = WW'(MaxWidth);
    end else begin
      w_clamp = WW'(frame_width);
    end
    if (frame_height < HB'(MIN_SIZE)) begin
      h_clamp = HB'(MIN_SIZE);
    end else if (frame_height > HB'(MAX_HEIGHT)) begin
      h_clamp = HB'(MAX_HEIGHT);
    end else begin
      h_clamp = frame_height;
    end
  end

  assign lag        = SW'({cur_w, 1'b0}) + SW'(2);
  assign frame_done = row_count >= cur_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stage_two    <= 1'b0;
      do2          <= 1'b0;
      frame_active <= 1'b0;
      cur_w        <= WW'(MaxWidth);
      cur_h        <= HB'(MAX_HEIGHT);
      col_count    <= '0;
      row_count    <= '0;
      step         <= '0;
      c1           <= '0;
      r1           <= '0;
      c2           <= '0;
      r2           <= '0;
    end else begin
      state        <= state_next;
      stage_two    <= stage_two_next;
      do2          <= do2_next;
      frame_active <= frame_active_next;
      cur_w        <= cur_w_next;
      cur_h        <= cur_h_next;
      col_count    <= col_count_next;
      row_count    <= row_count_next;
      step         <= step_next;
      c1           <= c1_next;
      r1           <= r1_next;
      c2           <= c2_next;
      r2           <= r2_next;
    end
  end

  always_comb begin
    state_next        = state;
    stage_two_next    = stage_two;
    do2_next          = do2;
    frame_active_next = frame_active;
    cur_w_next        = cur_w;
    cur_h_next        = cur_h;
    col_count_next    = col_count;
    row_count_next    = row_count;
    step_next         = step;
    c1_next           = c1;
    r1_next           = r1;
    c2_next           = c2;
    r2_next           = r2;

    cmd            = '0;
    cmd.write_row  = row_count;
    cmd.write_col  = COL_BITS'(col_count);
    cmd.stage_two  = stage_two;
    cmd.center_row = stage_two ? r2 : r1;
    cmd.center_col = stage_two ? COL_BITS'(c2) : COL_BITS'(c1);
    cmd.frame_w    = WIDTH_BITS'(cur_w);
    cmd.frame_h    = cur_h;
    cmd.eof        = (r2 == cur_h - HB'(1)) && (WW'(c2) == cur_w - WW'(1));
    in_ready       = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_drain) begin
            // A drain only counts once every pixel of the frame has arrived.
            if (frame_active && frame_done) begin
              state_next = S_STEP;
            end
          end else begin
            cmd.capture_pixel = 1'b1;
            if (!frame_active || frame_done) begin
              cur_w_next        = w_clamp;
              cur_h_next        = h_clamp;
              col_count_next    = '0;
              row_count_next    = '0;
              step_next         = '0;
              c1_next           = '0;
              r1_next           = '0;
              c2_next           = '0;
              r2_next           = '0;
              frame_active_next = 1'b1;
            end
            state_next = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.write_f = 1'b1;
        if (WW'(col_count) + WW'(1) >= cur_w) begin
          col_count_next = '0;
          row_count_next = row_count + HB'(1);
        end else begin
          col_count_next = col_count + CW'(1);
        end
        state_next = S_STEP;
      end
      S_STEP: begin
        step_next = step + SW'(1);
        do2_next  = (step >= {lag[SW-2:0], 1'b0}) && (r2 < cur_h);
        if ((step >= lag) && (r1 < cur_h)) begin
          stage_two_next = 1'b0;
          state_next     = S_BLUR;
        end else if ((step >= {lag[SW-2:0], 1'b0}) && (r2 < cur_h)) begin
          stage_two_next = 1'b1;
          state_next     = S_BLUR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_BLUR: begin
        cmd.blur_start = 1'b1;
        state_next     = S_BLUR_WAIT;
      end
      S_BLUR_WAIT: begin
        if (!status.blur_busy) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.prep_sum = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.prep_mul = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stage_two) begin
          cmd.write_b = 1'b1;
          if (WW'(c1) + WW'(1) >= cur_w) begin
            c1_next = '0;
            r1_next = r1 + HB'(1);
          end else begin
            c1_next = c1 + CW'(1);
          end
          if (do2) begin
            stage_two_next = 1'b1;
            state_next     = S_BLUR;
          end else begin
            state_next = S_IDLE;
          end
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (WW'(c2) + WW'(1) >= cur_w) begin
            c2_next = '0;
            r2_next = r2 + HB'(1);
          end else begin
            c2_next = c2 + CW'(1);
          end
          if (cmd.eof) begin
            frame_active_next = 1'b0;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_col_in_line: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (WW'(col_count) < cur_w))
    else $error("input column beyond line width");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (r2 <= r1))
    else $error("second stage ahead of first stage");

  a_first_behind_input: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (r1 <= row_count))
    else $error("first stage ahead of input");

  a_frame_closes: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.eof) |=> !frame_active)
    else $error("frame still active after last output");
`endif

endmodule

`default_nettype wire

/* design/cfa_tm_dp.sv */
// Datapath: line stores, serial blur, offsets, products, divider and output register.
`default_nettype none

module cfa_tm_dp #(
  parameter int MaxWidth  = cfa_tm_pkg::DEF_MAX_WIDTH,
  parameter int PixelBits = cfa_tm_pkg::DEF_PIXEL_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfa_tm_pkg::dp_cmd_t    cmd,
  output cfa_tm_pkg::dp_status_t status,
  input  logic [15:0]            raw_pixel,
  input  logic [31:0]            norm_scale,
  input  logic [15:0]            k1_offset,
  input  logic [15:0]            k2_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             tone_value,
  output logic                   end_of_frame
);
  import cfa_tm_pkg::*;

  localparam int CW    = $clog2(MaxWidth);
  localparam int WW    = $clog2(MaxWidth + 1);
  localparam int AW    = CW + RING_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int CS    = CW + 3;
  localparam int RS    = HEIGHT_BITS + 2;
  localparam int NUMW  = 44;
  localparam int DENW  = 35;
  localparam int CNTW  = $clog2(NUMW + 1);
  localparam logic [15:0] PIX_MASK = 16'((32'd1 << PixelBits) - 32'd1);

  logic [SAMPLE_BITS-1:0] norm_mem  [DEPTH];
  logic [SAMPLE_BITS-1:0] inter_mem [DEPTH];
  logic [SAMPLE_BITS-1:0] norm_q, inter_q;

  logic [47:0]            prod_f;
  logic [SAMPLE_BITS-1:0] f_val;

  logic                   blur_run, v1, v2;
  logic [2:0]             tr, tc;
  logic [4:0]             tidx, idx1;
  logic [WEIGHT_BITS+SAMPLE_BITS-1:0] mprod;
  logic [47:0]            acc;
  logic [SAMPLE_BITS-1:0] center_val, sample;
  logic [WEIGHT_BITS-1:0] weight;

  logic [RS-1:0]          row_s, row_m;
  logic [CS-1:0]          col_s, col_m;
  logic [AW-1:0]          rd_addr, wr_addr_f, wr_addr_b;

  logic [47:0]            acc_round;
  logic [17:0]            hval;
  logic [18:0]            hval_plus, den_sum;
  logic [34:0]            mul_reg;
  logic [DENW-1:0]        den_reg;
  logic [NUMW-1:0]        numerator;

  logic                   div_busy, den_zero;
  logic [CNTW-1:0]        div_cnt;
  logic [DENW:0]          div_rem, trial;
  logic [NUMW-1:0]        div_num, div_q;
  logic [SAMPLE_BITS-1:0] b_val;
  logic [TONE_BITS-1:0]   tone_val;

  // Normalisation: the product is taken at the accepting edge.
  always_ff @(posedge clk) begin
    if (cmd.capture_pixel) begin
      prod_f <= 48'(raw_pixel & PIX_MASK) * 48'(norm_scale);
    end
  end

  assign f_val = (|prod_f[47:32]) ? 16'hFFFF : prod_f[31:16];

  // Window position with mirror reflection that does not repeat the edge sample.
  always_comb begin
    row_s = RS'(cmd.center_row) + RS'(tr) - RS'(2);
    if (row_s[RS-1]) begin
      row_m = RS'(0) - row_s;
    end else if (row_s >= RS'(cmd.frame_h)) begin
      row_m = RS'({RS'(cmd.frame_h) - RS'(1), 1'b0}) - row_s;
    end else begin
      row_m = row_s;
    end
    col_s = CS'(cmd.center_col[CW-1:0]) + CS'(tc) - CS'(2);
    if (col_s[CS-1]) begin
      col_m = CS'(0) - col_s;
    end else if (col_s >= CS'(cmd.frame_w[WW-1:0])) begin
      col_m = CS'({CS'(cmd.frame_w[WW-1:0]) - CS'(1), 1'b0}) - col_s;
    end else begin
      col_m = col_s;
    end
  end

  assign rd_addr   = {row_m[RING_BITS-1:0], col_m[CW-1:0]};
  assign wr_addr_f = {cmd.write_row[RING_BITS-1:0], cmd.write_col[CW-1:0]};
  assign wr_addr_b = {cmd.center_row[RING_BITS-1:0], cmd.center_col[CW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.write_f) begin
      norm_mem[wr_addr_f] <= f_val;
    end
    norm_q <= norm_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_b) begin
      inter_mem[wr_addr_b] <= b_val;
    end
    inter_q <= inter_mem[rd_addr];
  end

  // Blur: one window sample per cycle through read, weight and accumulate stages.
  assign sample = cmd.stage_two ? inter_q : norm_q;
  assign weight = cmd.stage_two ? NARROW_WEIGHTS[idx1] : WIDE_WEIGHTS[idx1];

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_run <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      tr       <= '0;
      tc       <= '0;
      tidx     <= '0;
    end else begin
      v1 <= blur_run;
      v2 <= v1;
      if (cmd.blur_start) begin
        blur_run <= 1'b1;
        tr       <= '0;
        tc       <= '0;
        tidx     <= '0;
      end else if (blur_run) begin
        if (tidx == 5'(NUM_TAPS - 1)) begin
          blur_run <= 1'b0;
        end
        tidx <= tidx + 5'd1;
        if (tc == 3'(KERNEL_SIZE - 1)) begin
          tc <= '0;
          tr <= tr + 3'd1;
        end else begin
          tc <= tc + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= tidx;
    if (v1) begin
      mprod <= (WEIGHT_BITS + SAMPLE_BITS)'(weight) * (WEIGHT_BITS + SAMPLE_BITS)'(sample);
      if (idx1 == 5'(CENTER_TAP)) begin
        center_val <= sample;
      end
    end
    if (cmd.blur_start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + 48'(mprod);
    end
  end

  // Offset, then the numerator product and the denominator.
  assign acc_round = acc + 48'h0000_8000_0000;
  assign hval_plus = 19'(hval) + 19'd65536;
  assign den_sum   = 19'(center_val) + 19'(hval);

  always_ff @(posedge clk) begin
    if (cmd.prep_sum) begin
      hval <= 18'(acc_round[47:32]) +
              {1'b0, (cmd.stage_two ? k2_offset : k1_offset), 1'b0};
    end
    if (cmd.prep_mul) begin
      mul_reg <= 35'(hval_plus) * 35'(center_val);
      den_reg <= cmd.stage_two ? {den_sum, 16'b0} : DENW'(den_sum);
    end
  end

  always_comb begin
    if (cmd.stage_two) begin
      numerator = (NUMW'(mul_reg) << 8) - NUMW'(mul_reg) + NUMW'(den_reg >> 1);
    end else begin
      numerator = NUMW'(mul_reg) + NUMW'(den_reg >> 1);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign trial = {div_rem[DENW-1:0], div_num[NUMW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= CNTW'(NUMW);
    end else if (div_busy) begin
      div_cnt <= div_cnt - CNTW'(1);
      if (div_cnt == CNTW'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem  <= '0;
      div_num  <= numerator;
      div_q    <= '0;
      den_zero <= (den_reg == '0);
    end else if (div_busy) begin
      div_num <= {div_num[NUMW-2:0], 1'b0};
      if (trial >= {1'b0, den_reg}) begin
        div_rem <= trial - {1'b0, den_reg};
        div_q   <= {div_q[NUMW-2:0], 1'b1};
      end else begin
        div_rem <= trial;
        div_q   <= {div_q[NUMW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (den_zero) begin
      b_val    = '0;
      tone_val = '0;
    end else begin
      b_val    = (|div_q[NUMW-1:16]) ? 16'hFFFF : div_q[15:0];
      tone_val = (|div_q[NUMW-1:8]) ? 8'hFF : div_q[7:0];
    end
  end

  // Output register: a result waits here while the next beat is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tone_value   <= tone_val;
      end_of_frame <= cmd.eof;
    end
  end

  assign status.blur_busy = blur_run | v1 | v2;
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

/* bench/tb_cfa_tone_map_gaussian_core.sv */
// Self-checking testbench for the two-stage Gaussian tone mapping core.
`timescale 1ns / 100ps

module tb_cfa_tone_map_gaussian_core;
  import cfa_tm_pkg::*;

  localparam int MAXW          = DEF_MAX_WIDTH;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 250;
  localparam int TARGET_BEATS  = 1850;

  typedef struct {
    logic [15:0] raw;
    logic        drn;
  } pix_beat_t;

  typedef struct {
    logic [7:0] tone;
    logic       eof;
  } tone_beat_t;

  logic clk;
  logic rst;

  cfa_tm_pix_if  pix ();
  cfa_tm_tone_if tone ();
  cfa_tm_cfg_if  cfg ();

  cfa_tone_map_gaussian_core dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix),
    .tones  (tone),
    .cfg    (cfg)
  );

  pix_beat_t  beat_queue [$];
  tone_beat_t tone_expected [$];

  // Mirror of the register bank and of the frame position.
  logic [31:0] reg_scale;
  logic [15:0] reg_k1, reg_k2;
  logic [11:0] reg_w, reg_h;
  int unsigned cur_w, cur_h, col_pos, row_pos, step_pos;
  bit          frame_on;
  bit [15:0]   f_ring [8][MAXW];
  bit [15:0]   b_ring [8][MAXW];

  int  error_count, beats_in, tones_seen, items_sent, cfg_writes, settings_run;
  bit  sender_gappy, sink_gappy, hold_used;
  int  hold_left, quiet_cycles;

  always #10 clk = ~clk;

  function automatic int unsigned reflect(int i, int unsigned n);
    if (i < 0) return -i;
    if (i >= int'(n)) return 2 * (int'(n) - 1) - i;
    return i;
  endfunction

  function automatic longint unsigned gauss(bit narrow, int r, int c);
    longint unsigned acc, tr, tc, v;
    int unsigned rr, cc;
    acc = 0;
    for (int dr = -2; dr <= 2; dr++) begin
      rr = reflect(r + dr, cur_h);
      tr = narrow ? NARROW_TAPS[dr + 2] : WIDE_TAPS[dr + 2];
      for (int dc = -2; dc <= 2; dc++) begin
        cc = reflect(c + dc, cur_w);
        tc = narrow ? NARROW_TAPS[dc + 2] : WIDE_TAPS[dc + 2];
        v  = narrow ? b_ring[rr % 8][cc % MAXW] : f_ring[rr % 8][cc % MAXW];
        acc += tr * tc * v;
      end
    end
    return (acc + 64'h8000_0000) >> 32;
  endfunction

  function automatic void form_intermediate(int unsigned idx);
    int unsigned r, c;
    longint unsigned f, h, den, b;
    r   = idx / cur_w;
    c   = idx % cur_w;
    f   = f_ring[r % 8][c % MAXW];
    h   = gauss(1'b0, r, c) + 2 * longint'(reg_k1);
    den = f + h;
    b   = 0;
    if (den != 0) b = ((h + 65536) * f + den / 2) / den;
    if (b > 65535) b = 65535;
    b_ring[r % 8][c % MAXW] = b[15:0];
  endfunction

  function automatic logic [7:0] tone_of(int unsigned idx);
    int unsigned r, c;
    longint unsigned a, b, den, q;
    r   = idx / cur_w;
    c   = idx % cur_w;
    b   = b_ring[r % 8][c % MAXW];
    a   = gauss(1'b1, r, c) + 2 * longint'(reg_k2);
    den = (b + a) << 16;
    q   = 0;
    if (den != 0) q = (255 * (a + 65536) * b + den / 2) / den;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic int unsigned clamp_size(logic [11:0] v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the frame position by one accepted pixel beat and queues any tone value due.
  function automatic void take_beat(logic [15:0] raw, logic drn);
    int unsigned total, got, lag, s, o;
    longint unsigned fv;
    tone_beat_t tb;
    total = cur_w * cur_h;
    got   = row_pos * cur_w + col_pos;
    lag   = 2 * (cur_w + 1);
    if (!drn) begin
      fv = (longint'(raw) * longint'(reg_scale)) >> 16;
      if (!frame_on || got >= total) begin
        cur_w    = clamp_size(reg_w, MAXW);
        cur_h    = clamp_size(reg_h, MAX_HEIGHT);
        col_pos  = 0;
        row_pos  = 0;
        step_pos = 0;
        frame_on = 1;
        total    = cur_w * cur_h;
        lag      = 2 * (cur_w + 1);
      end
      if (fv > 65535) fv = 65535;
      f_ring[row_pos % 8][col_pos % MAXW] = fv[15:0];
      col_pos++;
      if (col_pos >= cur_w) begin
        col_pos = 0;
        row_pos++;
      end
    end else if (!frame_on || got < total) begin
      return;
    end
    s = step_pos;
    step_pos++;
    if (s >= lag && s - lag < total) form_intermediate(s - lag);
    if (s >= 2 * lag && s - 2 * lag < total) begin
      o       = s - 2 * lag;
      tb.tone = tone_of(o);
      tb.eof  = (o == total - 1);
      tone_expected.push_back(tb);
      if (tb.eof) frame_on = 0;
    end
  endfunction

  // Pixel driver.
  always @(posedge clk) begin
    pix_beat_t nb;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        take_beat(pix.raw_pixel, pix.drain);
        beats_in <= beats_in + 1;
      end
      if (!pix.valid || pix.ready) begin
        if (beat_queue.size() > 0 && !(sender_gappy && $urandom_range(99) < 10)) begin
          nb = beat_queue.pop_front();
          pix.valid     <= 1'b1;
          pix.raw_pixel <= nb.raw;
          pix.drain     <= nb.drn;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Tone receiver and checker.
  always @(posedge clk) begin
    tone_beat_t eb;
    if (rst) begin
      tone.ready <= 1'b0;
    end else begin
      if (tone.valid && tone.ready) begin
        tones_seen <= tones_seen + 1;
        if (tone_expected.size() == 0) begin
          $error("unexpected tone beat: tone_value=%0d end_of_frame=%0b",
                 tone.tone_value, tone.end_of_frame);
          error_count++;
        end else begin
          eb = tone_expected.pop_front();
          if (tone.tone_value !== eb.tone) begin
            $error("tone_value: expected %0d, got %0d", eb.tone, tone.tone_value);
            error_count++;
          end
          if (tone.end_of_frame !== eb.eof) begin
            $error("end_of_frame: expected %0b, got %0b", eb.eof, tone.end_of_frame);
            error_count++;
          end
        end
      end
      // One long hold-off mid-run lets the core fill up and stall its input.
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        tone.ready <= 1'b0;
      end else if (!hold_used && beats_in >= 400) begin
        hold_used  <= 1'b1;
        hold_left  <= 1500;
        tone.ready <= 1'b0;
      end else begin
        tone.ready <= !(sink_gappy && $urandom_range(99) < 10);
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (tone.valid && tone.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_cfa_tone_map_gaussian_core: done, errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_NORM_SCALE:   reg_scale = val;
      CFG_K1_OFFSET:    reg_k1 = val[15:0];
      CFG_K2_OFFSET:    reg_k2 = val[15:0];
      CFG_FRAME_WIDTH:  reg_w = val[11:0];
      CFG_FRAME_HEIGHT: reg_h = val[11:0];
      default: ;
    endcase
  endtask

  // Waits until the core has nothing left to deliver, then lets it settle.
  task automatic wait_quiet();
    do @(posedge clk);
    while (beat_queue.size() != 0 || pix.valid || tone_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_beat(logic [15:0] raw, logic drn);
    pix_beat_t b;
    b.raw = raw;
    b.drn = drn;
    beat_queue.push_back(b);
    items_sent++;
  endtask

  task automatic write_all(logic [31:0] sc, logic [15:0] k1, logic [15:0] k2,
                           logic [11:0] w, logic [11:0] h);
    write_reg(CFG_NORM_SCALE, sc);
    write_reg(CFG_K1_OFFSET, {16'd0, k1});
    write_reg(CFG_K2_OFFSET, {16'd0, k2});
    write_reg(CFG_FRAME_WIDTH, {20'd0, w});
    write_reg(CFG_FRAME_HEIGHT, {20'd0, h});
    settings_run++;
  endtask

  // Queues one frame at the latched size; a cut frame stops short of its flush.
  task automatic queue_frame(int style, bit cut_short);
    logic [15:0] extremes [6] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000};
    logic [15:0] base, px;
    int unsigned w, h, n_flush;
    w    = clamp_size(reg_w, MAXW);
    h    = clamp_size(reg_h, MAX_HEIGHT);
    base = 16'($urandom_range(0, 65535));
    for (int i = 0; i < w * h; i++) begin
      case (style)
        0:       px = extremes[i % 6];
        1:       px = 16'($urandom_range(0, 65535));
        2:       px = 16'($urandom_range(0, 255));
        default: px = base ^ 16'($urandom_range(0, 63));
      endcase
      push_beat(px, 1'b0);
      // A drain in the middle of the frame must be ignored.
      if (i < w * h - 1 && $urandom_range(99) < 4)
        push_beat(16'($urandom_range(0, 65535)), 1'b1);
    end
    n_flush = cut_short ? $urandom_range(0, 4 * (w + 1) - 1) : 4 * (w + 1);
    for (int i = 0; i < n_flush; i++) push_beat(16'($urandom_range(0, 65535)), 1'b1);
    if (!cut_short && $urandom_range(3) == 0) begin
      push_beat(16'hFFFF, 1'b1);
      push_beat(16'h0000, 1'b1);
    end
  endtask

  function automatic logic [11:0] pick_size(bit is_width);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 6) return 12'($urandom_range(0, 4));
    if (is_width && p < 11) return 12'd24;
    return is_width ? 12'($urandom_range(5, 9)) : 12'($urandom_range(5, 7));
  endfunction

  initial begin
    logic [31:0] sc;
    logic [15:0] k1, k2;
    int          phase_no;
    clk           = 1'b0;
    rst           = 1'b1;
    pix.valid     = 1'b0;
    pix.raw_pixel = '0;
    pix.drain     = 1'b0;
    tone.ready    = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = CFG_NORM_SCALE;
    cfg.data      = '0;
    reg_scale     = NORM_SCALE_RESET;
    reg_k1        = '0;
    reg_k2        = '0;
    reg_w         = FRAME_SIZE_RESET;
    reg_h         = FRAME_SIZE_RESET;
    cur_w         = MAXW;
    cur_h         = MAX_HEIGHT;
    frame_on      = 0;
    sender_gappy  = 1;
    sink_gappy    = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Largest register codes first, then a small frame before any pixel arrives.
    write_all(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
    write_all(NORM_SCALE_RESET, 16'd0, 16'd0, 12'd5, 12'd5);
    push_beat(16'h1234, 1'b1);  // drain while idle
    queue_frame(0, 1'b0);
    wait_quiet();
    // Zero scale makes every denominator zero.
    write_all(32'd0, 16'd0, 16'd0, 12'd5, 12'd5);
    queue_frame(0, 1'b0);
    wait_quiet();
    // Saturated samples, full offsets and undersized frames clamped up.
    write_all(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 12'd0, 12'd0);
    queue_frame(0, 1'b0);

    phase_no = 0;
    while (items_sent < TARGET_BEATS) begin
      phase_no++;
      wait_quiet();
      sender_gappy = !(phase_no >= 4 && phase_no <= 7);
      sink_gappy   = sender_gappy;
      case ($urandom_range(5))
        0:       sc = 32'd0;
        1:       sc = 32'hFFFF_FFFF;
        2:       sc = NORM_SCALE_RESET;
        default: sc = $urandom_range(16384, 262144);
      endcase
      k1 = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      k2 = ($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
      write_all(sc, k1, k2, pick_size(1'b1), pick_size(1'b0));
      for (int n = $urandom_range(1, 3); n > 0; n--)
        queue_frame($urandom_range(1, 3), $urandom_range(99) < 15);
    end

    wait_quiet();
    error_count += tone_expected.size();
    $display("Covered %0d pixel and drain beats, %0d tone values checked,", beats_in,
             tones_seen);
    $display("%0d register writes across %0d frame settings.", cfg_writes, settings_run);
    if (error_count == 0) begin
      $display("tb_cfa_tone_map_gaussian_core: done, clean");
    end else begin
      $display("tb_cfa_tone_map_gaussian_core: done, errors");
    end
    $finish;
  end

endmodule
